// ===== rtl/assert_macros.svh =====
// assertion macros shared by the parser rtl
// no dependencies; assertions drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under synchronous active-low reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/vsrp_pkg.sv =====
// shared types, codes and constants of the varint sensor record parser
// no dependencies
package vsrp_pkg;

    // default limit on the number of sub-readings
    localparam int unsigned C_MAX_SUBS = 16;

    // result queue geometry
    localparam int C_FIFO_DEPTH = 4;
    localparam int C_FIFO_AW    = $clog2(C_FIFO_DEPTH);
    localparam int C_FIFO_CW    = $clog2(C_FIFO_DEPTH + 1);

    // record fields, also the parser phase
    typedef enum logic [3:0] {
        TAG_ID     = 4'd0,
        TAG_TIME   = 4'd1,
        TAG_TEMP   = 4'd2,
        TAG_HUMID  = 4'd3,
        TAG_PRESS  = 4'd4,
        TAG_BATT   = 4'd5,
        TAG_STATUS = 4'd6,
        TAG_COUNT  = 4'd7,
        TAG_SUB    = 4'd8
    } t_tag;

    // error codes
    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_TOO_LONG = 3'd1,
        ERR_RANGE    = 3'd2,
        ERR_COUNT    = 3'd3,
        ERR_TRUNC    = 3'd4
    } t_err;

    // one result word
    typedef struct packed {
        t_tag        tag;
        logic [3:0]  idx;
        logic [63:0] value;
        t_err        err;
        logic        last;
    } t_result;

    // results produced by one input word, packed from res0 upwards
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_emit;

    // result queue status
    typedef struct packed {
        logic [C_FIFO_CW-1:0] count;
        logic                 room;
    } t_fifo_stat;

    // maximum varint length in bytes for each field
    function automatic logic [3:0] f_byte_limit(input t_tag tag);
        logic [3:0] lim;
        unique case (tag)
            TAG_ID, TAG_HUMID, TAG_BATT, TAG_SUB: lim = 4'd3;
            TAG_TIME, TAG_COUNT:                  lim = 4'd10;
            TAG_TEMP, TAG_PRESS, TAG_STATUS:      lim = 4'd5;
            default:                              lim = 4'd3;
        endcase
        return lim;
    endfunction

endpackage

// ===== rtl/vsrp_core.sv =====
// parser state and per-byte decode: varint assembly, range checks, zigzag
// depends on vsrp_pkg
module vsrp_core import vsrp_pkg::*; #(
    parameter int unsigned MAX_SUBS = C_MAX_SUBS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output t_emit      o_emit,
    output logic       o_halted
);

    localparam int POS_W = $clog2(MAX_SUBS + 1);

    t_tag             r_phase,  n_phase;
    logic [63:0]      r_acc,    n_acc;
    logic [3:0]       r_bcnt,   n_bcnt;
    logic [POS_W-1:0] r_total,  n_total;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_halted, n_halted;

    logic [6:0]       w_shamt;
    logic [63:0]      w_acc_new;
    logic [3:0]       w_cnt1;
    logic [31:0]      w_zz32;
    logic [15:0]      w_zz16;
    logic [63:0]      w_val;
    t_err             w_err;
    logic             w_done;
    t_tag             w_nph;
    logic [POS_W-1:0] w_npos;

    // build a result word; the index shows only on sub-readings
    function automatic t_result f_mk(input t_tag tag, input logic [POS_W-1:0] pos,
                                     input logic [63:0] value, input t_err err,
                                     input logic last);
        t_result r;
        r.tag   = tag;
        r.idx   = (tag == TAG_SUB) ? 4'(pos) : 4'd0;
        r.value = value;
        r.err   = err;
        r.last  = last;
        return r;
    endfunction

    // gather seven data bits at position 7 * byte count, bits past 63 dropped
    assign w_shamt   = {r_bcnt, 3'b000} - 7'(r_bcnt);
    assign w_acc_new = r_acc | (64'(i_data_byte[6:0]) << w_shamt);
    assign w_cnt1    = r_bcnt + 4'd1;

    // zigzag decode of the low bits only
    assign w_zz32 = w_acc_new[32:1] ^ {32{w_acc_new[0]}};
    assign w_zz16 = w_acc_new[16:1] ^ {16{w_acc_new[0]}};

    // field value and range check of a completed varint
    always_comb begin
        w_err = ERR_OK;
        w_val = w_acc_new;
        unique case (r_phase)
            TAG_ID, TAG_HUMID, TAG_BATT: begin
                if (w_acc_new[63:16] != '0) w_err = ERR_RANGE;
            end
            TAG_TEMP:   w_val = {{32{w_zz32[31]}}, w_zz32};
            TAG_PRESS: begin
                if (w_acc_new[63:32] != '0) w_err = ERR_RANGE;
            end
            TAG_STATUS: begin
                if (w_acc_new[63:2] != '0) w_err = ERR_RANGE;
            end
            TAG_COUNT: begin
                if (w_acc_new > 64'(MAX_SUBS)) w_err = ERR_COUNT;
            end
            TAG_SUB:    w_val = {{48{w_zz16[15]}}, w_zz16};
            default:    ;
        endcase
    end

    // next field and sub-reading position after a good varint
    always_comb begin
        w_done = 1'b0;
        w_nph  = r_phase;
        w_npos = r_pos;
        priority if (r_phase == TAG_COUNT) begin
            w_npos = '0;
            if (w_acc_new == 64'd0) w_done = 1'b1;
            else                    w_nph  = TAG_SUB;
        end else if (r_phase == TAG_SUB) begin
            w_npos = r_pos + POS_W'(1);
            if (w_npos >= r_total) w_done = 1'b1;
        end else begin
            w_nph = t_tag'(r_phase + 4'd1);
        end
    end

    // next state and results of one byte
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_bcnt   = r_bcnt;
        n_total  = r_total;
        n_pos    = r_pos;
        n_halted = r_halted;
        o_emit   = '0;
        if (i_fire) begin
            if (!r_halted) begin
                if (i_data_byte[7]) begin
                    // continuation byte
                    priority if (w_cnt1 >= f_byte_limit(r_phase)) begin
                        o_emit.valid0 = 1'b1;
                        o_emit.res0   = f_mk(r_phase, r_pos, 64'd0, ERR_TOO_LONG, 1'b1);
                        n_halted      = 1'b1;
                    end else if (i_frame_end) begin
                        o_emit.valid0 = 1'b1;
                        o_emit.res0   = f_mk(r_phase, r_pos, 64'd0, ERR_TRUNC, 1'b1);
                        n_halted      = 1'b1;
                    end else begin
                        n_acc  = w_acc_new;
                        n_bcnt = w_cnt1;
                    end
                end else begin
                    // final byte of a varint
                    n_acc         = '0;
                    n_bcnt        = '0;
                    o_emit.valid0 = 1'b1;
                    if (w_err != ERR_OK) begin
                        o_emit.res0 = f_mk(r_phase, r_pos, 64'd0, w_err, 1'b1);
                        n_halted    = 1'b1;
                    end else begin
                        o_emit.res0 = f_mk(r_phase, r_pos, w_val, ERR_OK, w_done);
                        n_phase     = w_nph;
                        n_pos       = w_npos;
                        if (r_phase == TAG_COUNT) n_total = w_acc_new[POS_W-1:0];
                        if (w_done) begin
                            n_halted = 1'b1;
                        end else if (i_frame_end) begin
                            o_emit.valid1 = 1'b1;
                            o_emit.res1   = f_mk(w_nph, w_npos, 64'd0, ERR_TRUNC, 1'b1);
                            n_halted      = 1'b1;
                        end
                    end
                end
            end
            // end of message returns everything to the start
            if (i_frame_end) begin
                n_phase  = TAG_ID;
                n_acc    = '0;
                n_bcnt   = '0;
                n_total  = '0;
                n_pos    = '0;
                n_halted = 1'b0;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= TAG_ID;
            r_acc    <= '0;
            r_bcnt   <= '0;
            r_total  <= '0;
            r_pos    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_bcnt   <= n_bcnt;
            r_total  <= n_total;
            r_pos    <= n_pos;
            r_halted <= n_halted;
        end
    end

    assign o_halted = r_halted;

endmodule

// ===== rtl/vsrp_res_fifo.sv =====
// result queue: takes up to two result words a cycle, gives one
// depends on vsrp_pkg
module vsrp_res_fifo import vsrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_emit      i_emit,
    input  logic       i_pop,
    output t_result    o_head,
    output t_fifo_stat o_stat
);

    t_result              r_mem [C_FIFO_DEPTH];
    logic [C_FIFO_AW-1:0] r_wr,    n_wr;
    logic [C_FIFO_AW-1:0] r_rd,    n_rd;
    logic [C_FIFO_CW-1:0] r_count, n_count;
    logic [C_FIFO_CW-1:0] w_npush;

    // pointer and fill bookkeeping
    always_comb begin
        w_npush = C_FIFO_CW'(i_emit.valid0) + C_FIFO_CW'(i_emit.valid1);
        n_wr    = r_wr + C_FIFO_AW'(w_npush);
        n_rd    = r_rd + C_FIFO_AW'(i_pop);
        n_count = r_count + w_npush - C_FIFO_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, second word goes in the slot after the first
    always_ff @(posedge i_clk) begin
        if (i_emit.valid0) r_mem[r_wr] <= i_emit.res0;
        if (i_emit.valid1) r_mem[r_wr + C_FIFO_AW'(1)] <= i_emit.res1;
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.room  = (r_count <= C_FIFO_CW'(C_FIFO_DEPTH - 2));

endmodule

// ===== rtl/varint_sensor_record_parser.sv =====
// top level of the varint sensor record parser: input register, core, result queue
// depends on vsrp_pkg, vsrp_core, vsrp_res_fifo and assert_macros.svh
//
// Parses a message of LEB128 varints, one byte per word, into sensor record
// fields and reports each field as a result word as soon as its last byte is
// seen; errors and an early frame end close the message with last set, and
// bytes after that are dropped until frame end. A byte is taken every cycle
// unless the input stalls: it is held in the input register, is decoded in a
// single pass by the core and lands in a four-entry result queue. The queue
// drains one word a cycle while the output is not stalled, which sets the
// sustained rate: one byte a cycle; a byte that ends a message early just as
// a field completes gives two result words. The input stalls only when
// the queue cannot take two more words.
`include "assert_macros.svh"

module varint_sensor_record_parser import vsrp_pkg::*; #(
    parameter int unsigned MAX_SUBS = C_MAX_SUBS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_field_tag,
    output logic [3:0]  o_sub_index,
    output logic [63:0] o_value,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fend;

    logic       w_load;
    logic       w_fire;
    logic       w_pop;
    logic       w_halted;
    t_emit      w_emit;
    t_result    w_head;
    t_fifo_stat w_fifo_stat;

    // handshake
    assign w_fire      = r_in_valid && w_fifo_stat.room;
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_load      = i_in_valid && !o_in_stall;
    assign o_out_valid = (w_fifo_stat.count != '0);
    assign w_pop       = o_out_valid && !i_out_stall;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_byte <= i_data_byte;
            r_in_fend <= i_frame_end;
        end
    end

    vsrp_core #(
        .MAX_SUBS (MAX_SUBS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_data_byte (r_in_byte),
        .i_frame_end (r_in_fend),
        .o_emit      (w_emit),
        .o_halted    (w_halted)
    );

    vsrp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fifo_stat)
    );

    // result word fields
    assign o_field_tag  = w_head.tag;
    assign o_sub_index  = w_head.idx;
    assign o_value      = w_head.value;
    assign o_error_code = w_head.err;
    assign o_last       = w_head.last;

    // checks
    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, w_fifo_stat.count <= C_FIFO_CW'(C_FIFO_DEPTH))
    `ASSERT_IMP(a_halt_quiet, i_clk, i_rst_n, w_fire && w_halted, !w_emit.valid0)
    `ASSERT_NXT(a_last_halts, i_clk, i_rst_n, w_fire && !r_in_fend && w_emit.valid0 && w_emit.res0.last, w_halted)
    `ASSERT_IMP(a_pair_trunc, i_clk, i_rst_n, w_emit.valid1, w_emit.valid0 && (w_emit.res1.err == ERR_TRUNC) && w_emit.res1.last)

endmodule
